/* src/cvme_pkg.sv */
`default_nettype none
package cvme_pkg;

    localparam int VALUE_BITS = 12;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam int IDX_W  = 5;
    localparam int IDX_XW = 7;
    localparam int SLOT_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int THR_PACK_W  = 48;
    localparam int NOTE_PACK_W = 28;

    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [7:0] ST_CC  = 8'hB0;
    localparam logic [7:0] ST_ON  = 8'h90;
    localparam logic [7:0] ST_OFF = 8'h80;
    localparam logic [6:0] MIDI_MAX = 7'd127;
    localparam logic [6:0] BASE_MAX = 7'd119;

    localparam logic [VALUE_BITS-1:0] HYST     = VALUE_BITS'((4095 * 7 + 50) / 100);
    localparam logic [VALUE_BITS-1:0] FLOOR_ON = VALUE_BITS'((4095 * 2 + 50) / 100);
    localparam logic [VALUE_BITS-1:0] THR_MIN  = VALUE_BITS'((4095 * 5 + 50) / 100);

    localparam logic [19:0] V7_DIV  = 20'(2 * 4095);
    localparam logic [19:0] V7_BIAS = 20'(4095);

    localparam logic [THR_PACK_W-1:0]  THR_RESET   = 48'h999_999_999_999;
    localparam logic [NOTE_PACK_W-1:0] NOTES_RESET = 28'd133144252;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF       = 3'd0,
        CFG_CC_BASE    = 3'd1,
        CFG_CHANNEL    = 3'd2,
        CFG_SEND_CC    = 3'd3,
        CFG_SEND_NOTES = 3'd4,
        CFG_THRESHOLDS = 3'd5,
        CFG_NOTES      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]            coef;
        logic [6:0]             cc_base;
        logic [4:0]             channel;
        logic                   send_cc;
        logic                   send_notes;
        logic [THR_PACK_W-1:0]  thresholds;
        logic [NOTE_PACK_W-1:0] notes;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]      index;
        logic [VALUE_BITS-1:0] target;
        logic                  in_range;
        logic                  is_live;
        logic [SLOT_W-1:0]     slot;
    } t_job;

    typedef struct packed {
        logic [VALUE_BITS-1:0] smoothed;
        logic                  msg_valid;
        logic [7:0]            status;
        logic [6:0]            data_first;
        logic [6:0]            data_second;
    } t_result;

endpackage
`default_nettype wire

/* src/cvme_fifo.sv */
`default_nettype none
module cvme_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    output logic                              o_full,
    input  wire logic                         i_pop,
    output logic [WIDTH-1:0]                  o_data,
    output logic                              o_empty,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

/* src/cvme_front.sv */
`default_nettype none
module cvme_front
    import cvme_pkg::*;
#(
    parameter int LIVE_SIGNALS  = 18,
    parameter int GESTURE_SLOTS = 4
) (
    input  wire logic [IDX_W-1:0]      i_signal_index,
    input  wire logic [VALUE_BITS-1:0] i_target_value,
    output t_job                       o_job
);
    logic [IDX_XW-1:0] idx_x, slot_x;

    assign idx_x  = {{(IDX_XW-IDX_W){1'b0}}, i_signal_index};
    assign slot_x = idx_x - IDX_XW'(LIVE_SIGNALS);

    always_comb begin
        o_job.index    = i_signal_index;
        o_job.target   = i_target_value;
        o_job.in_range = idx_x < IDX_XW'(LIVE_SIGNALS + GESTURE_SLOTS);
        o_job.is_live  = idx_x < IDX_XW'(LIVE_SIGNALS);
        o_job.slot     = slot_x[SLOT_W-1:0];
    end
endmodule
`default_nettype wire

/* src/cvme_back.sv */
`default_nettype none
module cvme_back
    import cvme_pkg::*;
#(
    parameter int LIVE_SIGNALS  = 18,
    parameter int GESTURE_SLOTS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire t_job                 i_job,
    input  wire logic                 i_job_avail,
    output logic                      o_job_pop,
    input  wire logic [RES_CNT_W-1:0] i_res_count,
    output logic                      o_res_push,
    output t_result                   o_res
);
    localparam int TOTAL = LIVE_SIGNALS + GESTURE_SLOTS;
    localparam int SAW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int LAW   = (LIVE_SIGNALS > 1) ? $clog2(LIVE_SIGNALS) : 1;

    logic [VALUE_BITS-1:0] r_store [TOTAL];
    logic [7:0]            r_last  [LIVE_SIGNALS];
    logic                  r_active[GESTURE_SLOTS];
    logic [6:0]            r_latch [GESTURE_SLOTS];

    // stage 1: read and multiply
    logic [IDX_XW-1:0]     idx1_x;
    logic [VALUE_BITS-1:0] s_old;
    logic signed [VALUE_BITS:0]   diff;
    logic signed [VALUE_BITS+17:0] prod;

    logic                  r_v2, r_v3;
    t_job                  r_job2, r_job3;
    logic signed [28:0]    r_prod;
    logic [VALUE_BITS-1:0] r_s3;

    // stage 2: round, add, clamp
    logic        neg;
    logic [28:0] mag;
    logic [28:0] rnd;
    logic [12:0] qm;
    logic signed [14:0] sum;
    logic [VALUE_BITS-1:0] s_new;
    logic [IDX_XW-1:0] idx2_x;

    // stage 3: scale, decide, emit
    logic [19:0] x, rem;
    logic [6:0]  q0, v7, vel;
    logic [IDX_XW-1:0] idx3_x;
    logic [LAW-1:0]    laddr;
    logic [6:0]  base_c;
    logic [7:0]  num8;
    logic [6:0]  num;
    logic        cc_send;
    logic [3:0]  chm1;
    logic [VALUE_BITS-1:0] thr_raw, thr, off_thr;
    logic        active, want, note_chg;
    logic [6:0]  note_new, note_out;

    assign o_job_pop = i_job_avail && !r_v2
                       && ({1'b0, i_res_count} + {{RES_CNT_W{1'b0}}, r_v3})
                          < (RES_CNT_W+1)'(RES_DEPTH);

    assign idx1_x = {{(IDX_XW-IDX_W){1'b0}}, i_job.index};
    assign s_old  = i_job.in_range ? r_store[idx1_x[SAW-1:0]] : '0;
    assign diff   = $signed({1'b0, s_old}) - $signed({1'b0, i_job.target});
    assign prod   = $signed({1'b0, i_cfg.coef}) * diff;

    always_comb begin
        neg = r_prod[28];
        mag = neg ? -r_prod : r_prod;
        rnd = mag + 29'd32768;
        qm  = rnd[28:16];
        sum = $signed({3'b0, r_job2.target})
              + (neg ? -$signed({2'b0, qm}) : $signed({2'b0, qm}));
        if (sum < 0) begin
            s_new = '0;
        end else if (sum > $signed({3'b0, VALUE_MAX})) begin
            s_new = VALUE_MAX;
        end else begin
            s_new = sum[VALUE_BITS-1:0];
        end
    end
    assign idx2_x = {{(IDX_XW-IDX_W){1'b0}}, r_job2.index};

    // v7 = (s*254 + 4095) / 8190; (s*254 + 4095)/8192 is the estimate, one step of correction
    always_comb begin
        x   = {r_s3, 8'b0} - {7'b0, r_s3, 1'b0} + V7_BIAS;
        q0  = x[19:13];
        rem = x - {q0, 13'b0} + {12'b0, q0, 1'b0};
        if (rem >= V7_DIV && q0 != MIDI_MAX) begin
            v7 = q0 + 1'b1;
        end else begin
            v7 = q0;
        end
        vel = (v7 == '0) ? 7'd1 : v7;
    end

    always_comb begin
        idx3_x  = {{(IDX_XW-IDX_W){1'b0}}, r_job3.index};
        laddr   = idx3_x[LAW-1:0];
        base_c  = (i_cfg.cc_base > BASE_MAX) ? BASE_MAX : i_cfg.cc_base;
        num8    = {1'b0, base_c} + {{(8-IDX_W){1'b0}}, r_job3.index};
        num     = (num8 > {1'b0, MIDI_MAX}) ? MIDI_MAX : num8[6:0];
        cc_send = i_cfg.send_cc && ({1'b0, v7} != r_last[laddr]);
        if (i_cfg.channel == 5'd0) begin
            chm1 = 4'd0;
        end else if (i_cfg.channel > 5'd16) begin
            chm1 = 4'd15;
        end else begin
            chm1 = 4'(i_cfg.channel - 5'd1);
        end

        thr_raw  = i_cfg.thresholds[r_job3.slot * VALUE_BITS +: VALUE_BITS];
        thr      = (thr_raw < THR_MIN) ? THR_MIN : thr_raw;
        off_thr  = (thr > HYST) ? thr - HYST : '0;
        off_thr  = (off_thr < FLOOR_ON) ? FLOOR_ON : off_thr;
        active   = r_active[r_job3.slot];
        want     = i_cfg.send_notes && (active ? (r_s3 > off_thr) : (r_s3 > thr));
        note_chg = want != active;
        note_new = i_cfg.notes[r_job3.slot * 7 +: 7];
        note_out = want ? note_new : r_latch[r_job3.slot];

        o_res = '0;
        if (r_job3.in_range) begin
            o_res.smoothed = r_s3;
            if (r_job3.is_live) begin
                if (cc_send) begin
                    o_res.msg_valid   = 1'b1;
                    o_res.status      = ST_CC | {4'b0, chm1};
                    o_res.data_first  = num;
                    o_res.data_second = v7;
                end
            end else if (note_chg) begin
                o_res.msg_valid   = 1'b1;
                o_res.status      = (want ? ST_ON : ST_OFF) | {4'b0, chm1};
                o_res.data_first  = note_out;
                o_res.data_second = want ? vel : 7'd0;
            end
        end
    end
    assign o_res_push = r_v3;

    always_ff @(posedge i_clk) begin
        r_job2 <= i_job;
        r_prod <= prod[28:0];
        r_job3 <= r_job2;
        r_s3   <= s_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            for (int i = 0; i < TOTAL; i++) begin
                r_store[i] <= '0;
            end
            for (int i = 0; i < LIVE_SIGNALS; i++) begin
                r_last[i] <= 8'hFF;
            end
            for (int i = 0; i < GESTURE_SLOTS; i++) begin
                r_active[i] <= 1'b0;
                r_latch[i]  <= '0;
            end
        end else begin
            r_v2 <= o_job_pop;
            r_v3 <= r_v2;
            if (r_v2 && r_job2.in_range) begin
                r_store[idx2_x[SAW-1:0]] <= s_new;
            end
            if (r_v3 && r_job3.in_range) begin
                if (r_job3.is_live) begin
                    if (cc_send) begin
                        r_last[laddr] <= {1'b0, v7};
                    end
                end else if (note_chg) begin
                    r_active[r_job3.slot] <= want;
                    if (want) begin
                        r_latch[r_job3.slot] <= note_new;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* src/control_value_to_midi_events_core.sv */
// An accepted input beat passes the job queue and the stage-2 and stage-3 registers of the
//   3-stage smoothing pipeline. No new item is taken while one is in stage 2, so a store
//   write-back lands before the next read, nor while the result queue may lack room.
// Reset (synchronous, i_rst_n low): queues empty, smoothed values zero, last-sent values
//   set to 8'hFF, notes off, config registers to their defaults.
`default_nettype none
module control_value_to_midi_events_core
    import cvme_pkg::*;
#(
    parameter int LIVE_SIGNALS  = 18,
    parameter int GESTURE_SLOTS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [IDX_W-1:0]      i_signal_index,
    input  wire logic [VALUE_BITS-1:0] i_target_value,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [VALUE_BITS-1:0]      o_smoothed_value,
    output logic                       o_message_valid,
    output logic [7:0]                 o_status_byte,
    output logic [6:0]                 o_data_first,
    output logic [6:0]                 o_data_second,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cfg    r_cfg;
    t_job    front_job, job_head;
    logic    job_empty, job_pop;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
    t_result res_in, res_head;
    logic    res_push;
    logic [RES_CNT_W-1:0] res_count;
    logic    res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef       <= '0;
            r_cfg.cc_base    <= 7'd30;
            r_cfg.channel    <= 5'd1;
            r_cfg.send_cc    <= 1'b1;
            r_cfg.send_notes <= 1'b1;
            r_cfg.thresholds <= THR_RESET;
            r_cfg.notes      <= NOTES_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COEF:       r_cfg.coef       <= i_cfg_data[15:0];
                CFG_CC_BASE:    r_cfg.cc_base    <= i_cfg_data[6:0];
                CFG_CHANNEL:    r_cfg.channel    <= i_cfg_data[4:0];
                CFG_SEND_CC:    r_cfg.send_cc    <= i_cfg_data[0];
                CFG_SEND_NOTES: r_cfg.send_notes <= i_cfg_data[0];
                CFG_THRESHOLDS: r_cfg.thresholds <= i_cfg_data[THR_PACK_W-1:0];
                CFG_NOTES:      r_cfg.notes      <= i_cfg_data[NOTE_PACK_W-1:0];
                default: ;
            endcase
        end
    end

    cvme_front #(
        .LIVE_SIGNALS  (LIVE_SIGNALS),
        .GESTURE_SLOTS (GESTURE_SLOTS)
    ) u_front (
        .i_signal_index (i_signal_index),
        .i_target_value (i_target_value),
        .o_job          (front_job)
    );

    cvme_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty),
        .o_count (job_count)
    );

    cvme_back #(
        .LIVE_SIGNALS  (LIVE_SIGNALS),
        .GESTURE_SLOTS (GESTURE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (job_head),
        .i_job_avail (!job_empty && (job_count != '0)),
        .o_job_pop   (job_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    cvme_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !res_full),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_smoothed_value = res_head.smoothed;
    assign o_message_valid  = res_head.msg_valid;
    assign o_status_byte    = res_head.status;
    assign o_data_first     = res_head.data_first;
    assign o_data_second    = res_head.data_second;
endmodule
`default_nettype wire
